FILE: hdl/ssr_pkg.sv
package ssr_pkg;

   localparam int SECT_W    = 48;
   localparam int CHUNK_W   = 21;
   localparam int ZCNT_W    = 4;
   localparam int MAX_ZONES = 8;
   localparam int ZIDX_W    = 3;
   localparam int MAX_DISKS = 16;
   localparam int SIDX_W    = 4;
   localparam int MEMB_W    = 5;
   localparam int DEV_W     = 4;
   localparam int LEN_W     = 16;
   localparam int OP_W      = 2;
   localparam int DIV2_W    = CHUNK_W + MEMB_W;
   localparam int CNT_W     = 6;
   localparam int SLOT_AW   = ZIDX_W + SIDX_W;

   localparam logic [OP_W-1:0] OP_MAP     = 2'd0;
   localparam logic [OP_W-1:0] OP_ZONE_WR = 2'd1;
   localparam logic [OP_W-1:0] OP_SLOT_WR = 2'd2;

   localparam logic CSR_CHUNK = 1'b0;
   localparam logic CSR_ZCNT  = 1'b1;

   localparam logic [CHUNK_W-1:0] CHUNK_RESET = 21'd128;
   localparam logic [ZCNT_W-1:0]  ZCNT_RESET  = 4'd1;

   typedef enum logic [1:0] {
      CMD_MAP,
      CMD_ZONE,
      CMD_SLOT
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic [SECT_W-1:0]     sector;
      logic [LEN_W-1:0]      length_sectors;
      logic [ZIDX_W-1:0]     zone_index;
      logic [SECT_W-1:0]     zone_end_value;
      logic [SECT_W-1:0]     zone_disk_start;
      logic [MEMB_W-1:0]     zone_members;
      logic [SIDX_W-1:0]     slot_index;
      logic [DEV_W-1:0]      device_id;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_DIV1,
      ST_PREP,
      ST_DIV2,
      ST_MUL,
      ST_DONE
   } state_type;

endpackage

FILE: hdl/ssr_front.sv
module ssr_front import ssr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [SECT_W-1:0]   req_sector,
   input  logic [LEN_W-1:0]    req_length_sectors,
   input  logic [ZIDX_W-1:0]   req_zone_index,
   input  logic [SECT_W-1:0]   req_zone_end_value,
   input  logic [SECT_W-1:0]   req_zone_disk_start,
   input  logic [MEMB_W-1:0]   req_zone_members,
   input  logic [SIDX_W-1:0]   req_slot_index,
   input  logic [DEV_W-1:0]    req_device_id,
   output queue_head_type      q_head,
   input  logic                q_pop
);

   cmd_type     buf_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        known_op;
   logic        push;
   cmd_type     cmd_new;

   always_comb begin
      cmd_new.sector          = req_sector;
      cmd_new.length_sectors  = req_length_sectors;
      cmd_new.zone_index      = req_zone_index;
      cmd_new.zone_end_value  = req_zone_end_value;
      cmd_new.zone_disk_start = req_zone_disk_start;
      cmd_new.zone_members    = req_zone_members;
      cmd_new.slot_index      = req_slot_index;
      cmd_new.device_id       = req_device_id;
      known_op                = 1'b1;
      unique case (req_operation)
         OP_MAP:     cmd_new.kind = CMD_MAP;
         OP_ZONE_WR: cmd_new.kind = CMD_ZONE;
         OP_SLOT_WR: cmd_new.kind = CMD_SLOT;
         default: begin
            cmd_new.kind = CMD_MAP;
            known_op     = 1'b0;
         end
      endcase
   end

   // Unknown operations are taken and dropped here.
   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall && known_op;

   assign q_head.valid = (cnt_ff != 2'd0);
   assign q_head.cmd   = buf_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count above depth");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> cnt_ff != 2'd0) else $error("pop from empty queue");
   a_cnt_track: assert property (@(posedge clock) disable iff (reset)
      (push && !q_pop) |=> cnt_ff == $past(cnt_ff) + 2'd1)
      else $error("queue count lost a push");

endmodule

FILE: hdl/ssr_back.sv
module ssr_back import ssr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic                csr_index,
   input  logic [CHUNK_W-1:0]  csr_data,
   input  queue_head_type      q_head,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [ZIDX_W-1:0]   rsp_zone_hit,
   output logic [SIDX_W-1:0]   rsp_slot_hit,
   output logic [DEV_W-1:0]    rsp_target_device,
   output logic [SECT_W-1:0]   rsp_device_sector,
   output logic                rsp_crosses_chunk,
   output logic                rsp_out_of_range
);

   state_type state_ff, state_in;

   logic [CHUNK_W-1:0] chunk_ff;
   logic [ZCNT_W-1:0]  zcnt_ff;

   logic [SECT_W-1:0]  end_ff   [MAX_ZONES];
   logic [SECT_W-1:0]  start_ff [MAX_ZONES];
   logic [MEMB_W-1:0]  memb_ff  [MAX_ZONES];
   logic [DEV_W-1:0]   slot_mem [MAX_ZONES * MAX_DISKS];
   logic [DEV_W-1:0]   slot_rd_ff;

   cmd_type            cmd_ff;
   logic [ZIDX_W-1:0]  zone_ff;
   logic               found_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [CHUNK_W-1:0] rem1_ff;
   logic [SECT_W-1:0]  quo1_ff;
   logic [DIV2_W-1:0]  dv2_ff;
   logic [DIV2_W-1:0]  rem2_ff;
   logic [SECT_W-1:0]  quo2_ff;
   logic [MEMB_W-1:0]  m_ff;
   logic [MEMB_W-1:0]  modr_ff;
   logic [SECT_W-1:0]  acc_ff;
   logic [SECT_W-1:0]  mcand_ff;
   logic               cross_ff;

   logic                rsp_valid_ff;
   logic [ZIDX_W-1:0]   zone_hit_ff;
   logic [SIDX_W-1:0]   slot_hit_ff;
   logic [DEV_W-1:0]    dev_ff;
   logic [SECT_W-1:0]   dsec_ff;
   logic                crosses_ff;
   logic                oor_ff;

   logic [CHUNK_W-1:0]  chunk_eff;
   logic [ZCNT_W-1:0]   nz;
   logic                find_hit;
   logic [ZIDX_W-1:0]   first_zone;
   logic [CHUNK_W:0]    trial1;
   logic                bit1;
   logic [DIV2_W:0]     trial2;
   logic                bit2;
   logic [MEMB_W:0]     trialm;
   logic                bitm;
   logic [MEMB_W-1:0]   m_eff;
   logic [SECT_W-1:0]   offset;
   logic [CHUNK_W+1:0]  cross_sum;
   logic                div_last;
   logic                mul_last;
   logic                out_free;

   assign chunk_eff = (chunk_ff == '0) ? CHUNK_W'(1) : chunk_ff;
   assign nz        = (zcnt_ff > ZCNT_W'(MAX_ZONES)) ? ZCNT_W'(MAX_ZONES) : zcnt_ff;
   assign div_last  = (cnt_ff == CNT_W'(SECT_W - 1));
   assign mul_last  = (cnt_ff == CNT_W'(CHUNK_W - 1));
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // First valid zone whose end lies above the sector.
   always_comb begin
      find_hit   = 1'b0;
      first_zone = '0;
      for (int i = MAX_ZONES - 1; i >= 0; i--) begin
         if ((ZCNT_W'(i) < nz) && (cmd_ff.sector < end_ff[i])) begin
            find_hit   = 1'b1;
            first_zone = ZIDX_W'(i);
         end
      end
   end

   always_comb begin
      trial1 = {rem1_ff, quo1_ff[SECT_W-1]};
      bit1   = (trial1 >= {1'b0, chunk_eff});
      trial2 = {rem2_ff, quo2_ff[SECT_W-1]};
      bit2   = (trial2 >= {1'b0, dv2_ff});
      trialm = {modr_ff, quo1_ff[SECT_W-1]};
      bitm   = (trialm >= {1'b0, m_ff});
   end

   always_comb begin
      m_eff = memb_ff[zone_ff];
      if (m_eff == '0) begin
         m_eff = MEMB_W'(1);
      end else if (m_eff > MEMB_W'(MAX_DISKS)) begin
         m_eff = MEMB_W'(MAX_DISKS);
      end
      if (zone_ff == '0) begin
         offset = cmd_ff.sector;
      end else begin
         offset = cmd_ff.sector - end_ff[zone_ff - ZIDX_W'(1)];
      end
      cross_sum = {1'b0, 1'b0, rem1_ff} + (CHUNK_W+2)'(cmd_ff.length_sectors);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_head.valid && q_head.cmd.kind == CMD_MAP) begin
               state_in = ST_FIND;
            end
         end
         ST_FIND: state_in = ST_DIV1;
         ST_DIV1: if (div_last) state_in = ST_PREP;
         ST_PREP: state_in = found_ff ? ST_DIV2 : ST_DONE;
         ST_DIV2: if (div_last) state_in = ST_MUL;
         ST_MUL:  if (mul_last) state_in = ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      q_pop = 1'b0;
      unique case (state_ff)
         ST_IDLE: q_pop = q_head.valid;
         default: q_pop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chunk_ff     <= CHUNK_RESET;
         zcnt_ff      <= ZCNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_CHUNK: chunk_ff <= csr_data;
               CSR_ZCNT:  zcnt_ff  <= csr_data[ZCNT_W-1:0];
               default:   chunk_ff <= chunk_ff;
            endcase
         end
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Table writes and the slot table read port.
   always_ff @(posedge clock) begin
      if (q_pop && q_head.cmd.kind == CMD_ZONE) begin
         end_ff[q_head.cmd.zone_index]   <= q_head.cmd.zone_end_value;
         start_ff[q_head.cmd.zone_index] <= q_head.cmd.zone_disk_start;
         memb_ff[q_head.cmd.zone_index]  <= q_head.cmd.zone_members;
      end
      if (q_pop && q_head.cmd.kind == CMD_SLOT) begin
         slot_mem[{q_head.cmd.zone_index, q_head.cmd.slot_index}] <= q_head.cmd.device_id;
      end
      slot_rd_ff <= slot_mem[{zone_ff, modr_ff[SIDX_W-1:0]}];
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            cmd_ff <= q_head.cmd;
         end
         ST_FIND: begin
            zone_ff  <= first_zone;
            found_ff <= find_hit;
            rem1_ff  <= '0;
            quo1_ff  <= cmd_ff.sector;
            cnt_ff   <= '0;
         end
         ST_DIV1: begin
            rem1_ff <= bit1 ? CHUNK_W'(trial1 - {1'b0, chunk_eff}) : trial1[CHUNK_W-1:0];
            quo1_ff <= {quo1_ff[SECT_W-2:0], bit1};
            cnt_ff  <= cnt_ff + CNT_W'(1);
         end
         ST_PREP: begin
            cross_ff <= (cross_sum > (CHUNK_W+2)'(chunk_eff));
            m_ff     <= m_eff;
            dv2_ff   <= DIV2_W'(chunk_eff) * DIV2_W'(m_eff);
            quo2_ff  <= offset;
            rem2_ff  <= '0;
            modr_ff  <= '0;
            cnt_ff   <= '0;
         end
         ST_DIV2: begin
            rem2_ff <= bit2 ? DIV2_W'(trial2 - {1'b0, dv2_ff}) : trial2[DIV2_W-1:0];
            quo2_ff <= {quo2_ff[SECT_W-2:0], bit2};
            modr_ff <= bitm ? MEMB_W'(trialm - {1'b0, m_ff}) : trialm[MEMB_W-1:0];
            quo1_ff <= {quo1_ff[SECT_W-2:0], 1'b0};
            if (div_last) begin
               acc_ff <= SECT_W'(rem1_ff) + start_ff[zone_ff];
               cnt_ff <= '0;
            end else begin
               cnt_ff <= cnt_ff + CNT_W'(1);
            end
         end
         ST_MUL: begin
            // Shift-and-add of the stripe row number by the chunk size.
            if (cnt_ff == '0) begin
               if (chunk_eff[0]) acc_ff <= acc_ff + quo2_ff;
               mcand_ff <= {quo2_ff[SECT_W-2:0], 1'b0};
            end else begin
               if (chunk_eff[cnt_ff[4:0]]) acc_ff <= acc_ff + mcand_ff;
               mcand_ff <= {mcand_ff[SECT_W-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         ST_DONE: begin
            if (out_free) begin
               crosses_ff <= cross_ff;
               oor_ff     <= !found_ff;
               if (found_ff) begin
                  zone_hit_ff <= zone_ff;
                  slot_hit_ff <= modr_ff[SIDX_W-1:0];
                  dev_ff      <= slot_rd_ff;
                  dsec_ff     <= acc_ff;
               end else begin
                  zone_hit_ff <= '0;
                  slot_hit_ff <= '0;
                  dev_ff      <= '0;
                  dsec_ff     <= '0;
               end
            end
         end
         default: begin
            cnt_ff <= cnt_ff;
         end
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_zone_hit      = zone_hit_ff;
   assign rsp_slot_hit      = slot_hit_ff;
   assign rsp_target_device = dev_ff;
   assign rsp_device_sector = dsec_ff;
   assign rsp_crosses_chunk = crosses_ff;
   assign rsp_out_of_range  = oor_ff;

   a_rem1_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV1 |-> rem1_ff < chunk_eff)
      else $error("chunk remainder not below chunk size");
   a_modr_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV2 |-> modr_ff < m_ff)
      else $error("slot remainder not below member count");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == ST_IDLE) else $error("queue popped while busy");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> cnt_ff < CNT_W'(CHUNK_W))
      else $error("multiply step count overran");

endmodule

FILE: hdl/striped_sector_remap_unit.sv
// A map request passes through the queue, the zone search, the chunk division,
// the setup step, the row division, the row multiply and the output load; a
// request past the last zone skips the row division and multiply. Map requests
// are handled one at a time: the next is not taken until the last result is
// loaded into the output register, which waits while the output is stalled.
// Reset (synchronous, active high) empties the queue and the output register and
// loads chunk size 128 and one zone; the zone and slot tables keep their contents.
module striped_sector_remap_unit import ssr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic                csr_index,
   input  logic [CHUNK_W-1:0]  csr_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [SECT_W-1:0]   req_sector,
   input  logic [LEN_W-1:0]    req_length_sectors,
   input  logic [ZIDX_W-1:0]   req_zone_index,
   input  logic [SECT_W-1:0]   req_zone_end_value,
   input  logic [SECT_W-1:0]   req_zone_disk_start,
   input  logic [MEMB_W-1:0]   req_zone_members,
   input  logic [SIDX_W-1:0]   req_slot_index,
   input  logic [DEV_W-1:0]    req_device_id,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [ZIDX_W-1:0]   rsp_zone_hit,
   output logic [SIDX_W-1:0]   rsp_slot_hit,
   output logic [DEV_W-1:0]    rsp_target_device,
   output logic [SECT_W-1:0]   rsp_device_sector,
   output logic                rsp_crosses_chunk,
   output logic                rsp_out_of_range
);

   queue_head_type q_head;
   logic           q_pop;

   ssr_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_sector          (req_sector),
      .req_length_sectors  (req_length_sectors),
      .req_zone_index      (req_zone_index),
      .req_zone_end_value  (req_zone_end_value),
      .req_zone_disk_start (req_zone_disk_start),
      .req_zone_members    (req_zone_members),
      .req_slot_index      (req_slot_index),
      .req_device_id       (req_device_id),
      .q_head              (q_head),
      .q_pop               (q_pop)
   );

   ssr_back u_back (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .q_head            (q_head),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_zone_hit      (rsp_zone_hit),
      .rsp_slot_hit      (rsp_slot_hit),
      .rsp_target_device (rsp_target_device),
      .rsp_device_sector (rsp_device_sector),
      .rsp_crosses_chunk (rsp_crosses_chunk),
      .rsp_out_of_range  (rsp_out_of_range)
   );

endmodule
